// ===== src/bba_pkg.sv =====
`timescale 1ns / 1ps

package bba_pkg;

  // default geometry
  localparam int TopLevelDef = 16;
  localparam int MinLevelDef = 6;

  // fixed field widths
  localparam int OpW   = 2;
  localparam int SizeW = 18;
  localparam int OffW  = 16;
  localparam int StW   = 2;

  // request codes
  localparam logic [OpW-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OpW-1:0] OP_FREE   = 2'd1;
  localparam logic [OpW-1:0] OP_REINIT = 2'd2;

  // result codes
  localparam logic [StW-1:0] ST_OK     = 2'd0;
  localparam logic [StW-1:0] ST_REJECT = 2'd1;
  localparam logic [StW-1:0] ST_NOMEM  = 2'd2;

  // datapath actions
  localparam int ActW = 4;
  localparam logic [ActW-1:0] ACT_NONE       = 4'd0;
  localparam logic [ActW-1:0] ACT_LOAD       = 4'd1;
  localparam logic [ActW-1:0] ACT_REINIT     = 4'd2;
  localparam logic [ActW-1:0] ACT_SCAN_UP    = 4'd3;
  localparam logic [ActW-1:0] ACT_RD_HEAD    = 4'd4;
  localparam logic [ActW-1:0] ACT_SPLIT_POP  = 4'd5;
  localparam logic [ActW-1:0] ACT_SPLIT_W1   = 4'd6;
  localparam logic [ActW-1:0] ACT_SPLIT_W2   = 4'd7;
  localparam logic [ActW-1:0] ACT_POP_DONE   = 4'd8;
  localparam logic [ActW-1:0] ACT_PUSH       = 4'd9;
  localparam logic [ActW-1:0] ACT_UL_START   = 4'd10;
  localparam logic [ActW-1:0] ACT_UL_RD      = 4'd11;
  localparam logic [ActW-1:0] ACT_UL_NEXT    = 4'd12;
  localparam logic [ActW-1:0] ACT_UL_REMOVE  = 4'd13;
  localparam logic [ActW-1:0] ACT_MERGE_PUSH = 4'd14;

  // controller to datapath
  typedef struct packed {
    logic [ActW-1:0] act;
    logic            self_tgt;
    logic            fin;
    logic [StW-1:0]  fin_st;
    logic            emit;
  } cmd_t;

  // datapath to controller
  typedef struct packed {
    logic [OpW-1:0] op;
    logic           size_ok;
    logic           addr_ok;
    logic           head_nil;
    logic           i_top;
    logic           i_sub_top;
    logic           i_want;
    logic           cur_end;
    logic           cur_hit;
    logic           out_free;
  } sts_t;

endpackage

// ===== src/bba_if.sv =====
`timescale 1ns / 1ps

// request channel
interface bba_in_if;
  logic                        valid;
  logic                        ready;
  logic [bba_pkg::OpW-1:0]     operation;
  logic [bba_pkg::SizeW-1:0]   size_bytes;
  logic [bba_pkg::OffW-1:0]    block_offset;

  modport source (output valid, output operation, output size_bytes, output block_offset,
                  input ready);
  modport sink (input valid, input operation, input size_bytes, input block_offset,
                output ready);
endinterface

// result channel
interface bba_out_if;
  logic                        valid;
  logic                        ready;
  logic [bba_pkg::StW-1:0]     status;
  logic [bba_pkg::OffW-1:0]    granted_offset;

  modport source (output valid, output status, output granted_offset, input ready);
  modport sink (input valid, input status, input granted_offset, output ready);
endinterface

// ===== src/bba_ram.sv =====
`timescale 1ns / 1ps

module bba_ram #(
  parameter int W = 8,
  parameter int D = 16
) (
  input  logic                 clk,
  input  logic                 we,
  input  logic [$clog2(D)-1:0] waddr,
  input  logic [W-1:0]         wdata,
  input  logic [$clog2(D)-1:0] raddr,
  output logic [W-1:0]         rdata
);

  logic [W-1:0] mem [D];

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/bba_ctrl.sv =====
`timescale 1ns / 1ps

module bba_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  input  bba_pkg::sts_t sts,
  output bba_pkg::cmd_t cmd
);

  localparam logic [3:0] S_IDLE     = 4'd0;
  localparam logic [3:0] S_DISP     = 4'd1;
  localparam logic [3:0] S_SCAN     = 4'd2;
  localparam logic [3:0] S_SPLIT_RD = 4'd3;
  localparam logic [3:0] S_SPLIT_WT = 4'd4;
  localparam logic [3:0] S_SPLIT_W1 = 4'd5;
  localparam logic [3:0] S_SPLIT_W2 = 4'd6;
  localparam logic [3:0] S_POP_RD   = 4'd7;
  localparam logic [3:0] S_POP_WT   = 4'd8;
  localparam logic [3:0] S_PUSH     = 4'd9;
  localparam logic [3:0] S_UL_BUD   = 4'd10;
  localparam logic [3:0] S_UL_SELF  = 4'd11;
  localparam logic [3:0] S_UL_CHK   = 4'd12;
  localparam logic [3:0] S_UL_WT    = 4'd13;
  localparam logic [3:0] S_MERGE    = 4'd14;
  localparam logic [3:0] S_DONE     = 4'd15;

  logic [3:0] state_r, state_nxt;
  logic       self_r, self_nxt;

  assign in_ready = (state_r == S_IDLE);

  // next state and commands
  always_comb begin
    state_nxt    = state_r;
    self_nxt     = self_r;
    cmd          = '0;
    cmd.act      = bba_pkg::ACT_NONE;
    cmd.self_tgt = self_r;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.act   = bba_pkg::ACT_LOAD;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (sts.op == bba_pkg::OP_REINIT) begin
          cmd.act    = bba_pkg::ACT_REINIT;
          cmd.fin    = 1'b1;
          cmd.fin_st = bba_pkg::ST_OK;
          state_nxt  = S_DONE;
        end else if (sts.op == bba_pkg::OP_ALLOC && sts.size_ok) begin
          state_nxt = S_SCAN;
        end else if (sts.op == bba_pkg::OP_FREE && sts.size_ok && sts.addr_ok) begin
          state_nxt = S_PUSH;
        end else begin
          cmd.fin    = 1'b1;
          cmd.fin_st = bba_pkg::ST_REJECT;
          state_nxt  = S_DONE;
        end
      end
      // look upward for a non-empty list
      S_SCAN: begin
        if (!sts.head_nil) begin
          state_nxt = sts.i_want ? S_POP_RD : S_SPLIT_RD;
        end else if (sts.i_top) begin
          cmd.fin    = 1'b1;
          cmd.fin_st = bba_pkg::ST_NOMEM;
          state_nxt  = S_DONE;
        end else begin
          cmd.act = bba_pkg::ACT_SCAN_UP;
        end
      end
      S_SPLIT_RD: begin
        cmd.act   = bba_pkg::ACT_RD_HEAD;
        state_nxt = S_SPLIT_WT;
      end
      S_SPLIT_WT: begin
        cmd.act   = bba_pkg::ACT_SPLIT_POP;
        state_nxt = S_SPLIT_W1;
      end
      S_SPLIT_W1: begin
        cmd.act   = bba_pkg::ACT_SPLIT_W1;
        state_nxt = S_SPLIT_W2;
      end
      S_SPLIT_W2: begin
        cmd.act   = bba_pkg::ACT_SPLIT_W2;
        state_nxt = S_SCAN;
      end
      S_POP_RD: begin
        cmd.act   = bba_pkg::ACT_RD_HEAD;
        state_nxt = S_POP_WT;
      end
      S_POP_WT: begin
        cmd.act    = bba_pkg::ACT_POP_DONE;
        cmd.fin    = 1'b1;
        cmd.fin_st = bba_pkg::ST_OK;
        state_nxt  = S_DONE;
      end
      S_PUSH: begin
        cmd.act = bba_pkg::ACT_PUSH;
        if (sts.i_top) begin
          cmd.fin    = 1'b1;
          cmd.fin_st = bba_pkg::ST_OK;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_UL_BUD;
        end
      end
      S_UL_BUD: begin
        cmd.act      = bba_pkg::ACT_UL_START;
        cmd.self_tgt = 1'b0;
        self_nxt     = 1'b0;
        state_nxt    = S_UL_CHK;
      end
      S_UL_SELF: begin
        cmd.act      = bba_pkg::ACT_UL_START;
        cmd.self_tgt = 1'b1;
        self_nxt     = 1'b1;
        state_nxt    = S_UL_CHK;
      end
      // list walk: read each node, then check it against the target
      S_UL_CHK: begin
        if (sts.cur_end) begin
          if (self_r) begin
            state_nxt = S_MERGE;
          end else begin
            cmd.fin    = 1'b1;
            cmd.fin_st = bba_pkg::ST_OK;
            state_nxt  = S_DONE;
          end
        end else begin
          cmd.act   = bba_pkg::ACT_UL_RD;
          state_nxt = S_UL_WT;
        end
      end
      S_UL_WT: begin
        if (sts.cur_hit) begin
          cmd.act   = bba_pkg::ACT_UL_REMOVE;
          state_nxt = self_r ? S_MERGE : S_UL_SELF;
        end else begin
          cmd.act   = bba_pkg::ACT_UL_NEXT;
          state_nxt = S_UL_CHK;
        end
      end
      S_MERGE: begin
        cmd.act = bba_pkg::ACT_MERGE_PUSH;
        if (sts.i_sub_top) begin
          cmd.fin    = 1'b1;
          cmd.fin_st = bba_pkg::ST_OK;
          state_nxt  = S_DONE;
        end else begin
          state_nxt = S_UL_BUD;
        end
      end
      S_DONE: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      self_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      self_r  <= self_nxt;
    end
  end

endmodule

// ===== src/bba_dp.sv =====
`timescale 1ns / 1ps

module bba_dp #(
  parameter int TOP_LEVEL = bba_pkg::TopLevelDef,
  parameter int MIN_LEVEL = bba_pkg::MinLevelDef
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  bba_pkg::cmd_t              cmd,
  output bba_pkg::sts_t              sts,
  input  logic [bba_pkg::OpW-1:0]    in_op,
  input  logic [bba_pkg::SizeW-1:0]  in_size,
  input  logic [bba_pkg::OffW-1:0]   in_offs,
  input  logic                       out_ready,
  output logic                       out_valid,
  output logic [bba_pkg::StW-1:0]    out_status,
  output logic [bba_pkg::OffW-1:0]   out_granted
);

  localparam int NLEV = TOP_LEVEL - MIN_LEVEL + 1;
  localparam int BW   = TOP_LEVEL - MIN_LEVEL + 1;
  localparam int AW   = BW - 1;
  localparam int NBLK = 2 ** AW;
  localparam int LW   = $clog2(NLEV);
  localparam logic [BW-1:0] NIL = {1'b1, {AW{1'b0}}};

  logic [bba_pkg::OpW-1:0]   op_r;
  logic [bba_pkg::SizeW-1:0] size_r;
  logic [bba_pkg::OffW-1:0]  offs_r;
  logic [LW-1:0]             want_r, i_r;
  logic [BW-1:0]             b_r, cur_r, pred_r, tgt_r, n_r;
  logic [bba_pkg::StW-1:0]   stat_r;
  logic [bba_pkg::OffW-1:0]  gran_r;
  logic [BW-1:0]             heads_r [NLEV];
  logic                      out_valid_r;
  logic [bba_pkg::StW-1:0]   out_status_r;
  logic [bba_pkg::OffW-1:0]  out_granted_r;

  logic [LW-1:0] hidx;
  logic [BW-1:0] hrd, bit_i, half, bh, merged;
  logic          we;
  logic [AW-1:0] waddr, raddr;
  logic [BW-1:0] wdata, rdata;

  // smallest level whose block holds the size
  function automatic logic [LW-1:0] level_of(input logic [bba_pkg::SizeW-1:0] sz);
    logic [LW-1:0] r;
    r = LW'(NLEV - 1);
    for (int lv = NLEV - 1; lv >= 0; lv--) begin
      if ((64'd1 << (lv + MIN_LEVEL)) >= 64'(sz)) r = LW'(lv);
    end
    return r;
  endfunction

  // head table read index for the current action
  always_comb begin
    case (cmd.act)
      bba_pkg::ACT_SPLIT_W1,
      bba_pkg::ACT_SPLIT_W2:   hidx = i_r - 1'b1;
      bba_pkg::ACT_MERGE_PUSH: hidx = i_r + 1'b1;
      default:                 hidx = i_r;
    endcase
  end
  assign hrd    = heads_r[hidx];
  assign bit_i  = BW'(1) << i_r;
  assign half   = BW'(1) << (i_r - 1'b1);
  assign bh     = b_r + half;
  assign merged = b_r & ~bit_i;

  // status toward the controller
  always_comb begin
    sts.op        = op_r;
    sts.size_ok   = (size_r != '0) && (64'(size_r) <= (64'd1 << TOP_LEVEL));
    sts.addr_ok   = (64'(offs_r) < (64'd1 << TOP_LEVEL)) &&
                    ((64'(offs_r) & ((64'd1 << (want_r + MIN_LEVEL)) - 64'd1)) == 64'd0);
    sts.head_nil  = heads_r[i_r][BW-1];
    sts.i_top     = (i_r == LW'(NLEV - 1));
    sts.i_sub_top = (i_r == LW'(NLEV - 2));
    sts.i_want    = (i_r == want_r);
    sts.cur_end   = cur_r[BW-1] | n_r[BW-1];
    sts.cur_hit   = (cur_r == tgt_r);
    sts.out_free  = !out_valid_r || out_ready;
  end

  // link memory port control
  always_comb begin
    we    = 1'b0;
    waddr = b_r[AW-1:0];
    wdata = hrd;
    raddr = cur_r[AW-1:0];
    case (cmd.act)
      bba_pkg::ACT_RD_HEAD: raddr = hrd[AW-1:0];
      bba_pkg::ACT_REINIT: begin
        we    = 1'b1;
        waddr = '0;
        wdata = NIL;
      end
      bba_pkg::ACT_SPLIT_W1: begin
        we    = 1'b1;
        waddr = bh[AW-1:0];
      end
      bba_pkg::ACT_SPLIT_W2,
      bba_pkg::ACT_PUSH: we = 1'b1;
      bba_pkg::ACT_UL_REMOVE: begin
        we    = !pred_r[BW-1];
        waddr = pred_r[AW-1:0];
        wdata = rdata;
      end
      bba_pkg::ACT_MERGE_PUSH: begin
        we    = 1'b1;
        waddr = merged[AW-1:0];
      end
      default: we = 1'b0;
    endcase
    // block zero alone on the top list after reset
    if (!rst_n) begin
      we    = 1'b1;
      waddr = '0;
      wdata = NIL;
    end
  end

  bba_ram #(.W(BW), .D(NBLK)) u_links (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // list heads, working registers and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NLEV; k++) heads_r[k] <= (k == NLEV - 1) ? '0 : NIL;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.emit) begin
        out_valid_r   <= 1'b1;
        out_status_r  <= stat_r;
        out_granted_r <= gran_r;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
      if (cmd.fin) stat_r <= cmd.fin_st;
      case (cmd.act)
        bba_pkg::ACT_LOAD: begin
          op_r   <= in_op;
          size_r <= in_size;
          offs_r <= in_offs;
          want_r <= level_of(in_size);
          i_r    <= level_of(in_size);
          b_r    <= BW'(in_offs >> MIN_LEVEL);
          gran_r <= '0;
        end
        bba_pkg::ACT_REINIT: begin
          for (int k = 0; k < NLEV; k++) heads_r[k] <= (k == NLEV - 1) ? '0 : NIL;
        end
        bba_pkg::ACT_SCAN_UP:   i_r <= i_r + 1'b1;
        bba_pkg::ACT_RD_HEAD:   b_r <= hrd;
        bba_pkg::ACT_SPLIT_POP: heads_r[i_r] <= rdata;
        bba_pkg::ACT_SPLIT_W1:  heads_r[hidx] <= bh;
        bba_pkg::ACT_SPLIT_W2: begin
          heads_r[hidx] <= b_r;
          i_r           <= i_r - 1'b1;
        end
        bba_pkg::ACT_POP_DONE: begin
          heads_r[i_r] <= rdata;
          gran_r       <= bba_pkg::OffW'(64'(b_r) << MIN_LEVEL);
        end
        bba_pkg::ACT_PUSH: heads_r[i_r] <= b_r;
        bba_pkg::ACT_UL_START: begin
          tgt_r  <= cmd.self_tgt ? b_r : (b_r ^ bit_i);
          pred_r <= NIL;
          cur_r  <= heads_r[i_r];
          n_r    <= '0;
        end
        bba_pkg::ACT_UL_NEXT: begin
          pred_r <= cur_r;
          cur_r  <= rdata;
          n_r    <= n_r + 1'b1;
        end
        bba_pkg::ACT_UL_REMOVE: begin
          if (pred_r[BW-1]) heads_r[i_r] <= rdata;
        end
        bba_pkg::ACT_MERGE_PUSH: begin
          heads_r[hidx] <= merged;
          b_r           <= merged;
          i_r           <= i_r + 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  assign out_valid   = out_valid_r;
  assign out_status  = out_status_r;
  assign out_granted = out_granted_r;

endmodule

// ===== src/buddy_block_allocator_core.sv =====
`timescale 1ns / 1ps
// Buddy allocator over a region of 2^TOP_LEVEL bytes, blocks of at least 2^MIN_LEVEL.
// in_chan (valid/ready) carries operation, size_bytes and block_offset: allocate,
// free or reinitialise. out_chan (valid/ready) returns one item per request: status
// and granted_offset (offset of an allocated block, zero otherwise).
// One request is in work at a time; in_chan.ready is high only while idle.
// An allocation scans upward past empty levels and splits blocks down to the wanted
// level; a free pushes the block, walks the list to unlink its buddy and then itself,
// and merges level by level. The list walks go through the one read port of the link
// memory one node at a time.
// The result sits in an output register; the next request is taken while it waits,
// and a finished request holds in its final state while out_chan stays stalled.
// Reset (rst_n low, synchronous) empties every list, places block zero on the top
// level and writes its link as end of list; every other link entry is written
// before it is read, so no clearing pass is needed.
module buddy_block_allocator_core #(
  parameter int TOP_LEVEL = bba_pkg::TopLevelDef,
  parameter int MIN_LEVEL = bba_pkg::MinLevelDef
) (
  input logic       clk,
  input logic       rst_n,
  bba_in_if.sink    in_chan,
  bba_out_if.source out_chan
);

  bba_pkg::cmd_t cmd;
  bba_pkg::sts_t sts;

  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .sts      (sts),
    .cmd      (cmd)
  );

  bba_dp #(.TOP_LEVEL(TOP_LEVEL), .MIN_LEVEL(MIN_LEVEL)) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .in_op       (in_chan.operation),
    .in_size     (in_chan.size_bytes),
    .in_offs     (in_chan.block_offset),
    .out_ready   (out_chan.ready),
    .out_valid   (out_chan.valid),
    .out_status  (out_chan.status),
    .out_granted (out_chan.granted_offset)
  );

endmodule

// ===== src/bba_chk.sv =====
`timescale 1ns / 1ps

module bba_chk #(
  parameter int MIN_LEVEL = bba_pkg::MinLevelDef
) (
  input logic                     clk,
  input logic                     rst_n,
  input logic                     in_valid,
  input logic                     in_ready,
  input logic                     out_valid,
  input logic                     out_ready,
  input logic [bba_pkg::StW-1:0]  status,
  input logic [bba_pkg::OffW-1:0] granted
);

  // stalled result holds
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(status) && $stable(granted))
    else $error("result changed under stall");

  // one request at a time
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while busy");

  // offset only on a successful allocation
  a_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && status != bba_pkg::ST_OK |-> granted == '0)
    else $error("offset on failed request");

  // granted blocks are aligned to the minimum block
  a_align: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (granted & ((bba_pkg::OffW'(1) << MIN_LEVEL) - 1'b1)) == '0)
    else $error("misaligned offset");

endmodule

bind buddy_block_allocator_core bba_chk #(.MIN_LEVEL(MIN_LEVEL)) u_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_chan.valid),
  .in_ready  (in_chan.ready),
  .out_valid (out_chan.valid),
  .out_ready (out_chan.ready),
  .status    (out_chan.status),
  .granted   (out_chan.granted_offset)
);
